FILE: src/nfba_pkg.sv
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and codes of the next-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

	localparam int REQ_W  = 16;
	localparam int OFF_W  = 16;
	localparam int BB_W   = 17;
	localparam int ZONE_W = 17;
	// Granules needed by the largest request fit in this many bits
	localparam int NEED_W = 14;
	localparam logic [ZONE_W-1:0] ZONE_RESET = 17'h0c000;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_NOSPACE = 3'd1,
		STAT_NULL    = 3'd2,
		STAT_BADMARK = 3'd3,
		STAT_DOUBLE  = 3'd4
	} status_t;

	typedef enum logic [11:0] {
		FS_IDLE  = 12'b0000_0000_0001,
		FS_CLR   = 12'b0000_0000_0010,
		FS_INIT  = 12'b0000_0000_0100,
		FS_A_ST  = 12'b0000_0000_1000,
		FS_A_EV  = 12'b0000_0001_0000,
		FS_A_AFT = 12'b0000_0010_0000,
		FS_F_B   = 12'b0000_0100_0000,
		FS_F_P   = 12'b0000_1000_0000,
		FS_F_N   = 12'b0001_0000_0000,
		FS_F_CAL = 12'b0010_0000_0000,
		FS_WR    = 12'b0100_0000_0000,
		FS_FIN   = 12'b1000_0000_0000
	} fsm_t;

endpackage

`default_nettype wire

FILE: src/nfba_if.sv
// ----------------------------------------------------------------------------
// nfba_if
// Request and result channels of the allocator (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface nfba_in_if import nfba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [REQ_W-1:0] req_bytes;
	logic [OFF_W-1:0] data_offset;
	logic             null_pointer;

	modport source (output valid, func, req_bytes, data_offset, null_pointer, input ready);
	modport sink (input valid, func, req_bytes, data_offset, null_pointer, output ready);
endinterface

interface nfba_out_if import nfba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [OFF_W-1:0] result_offset;
	logic [BB_W-1:0]  block_bytes;

	modport source (output valid, status, result_offset, block_bytes, input ready);
	modport sink (input valid, status, result_offset, block_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/next_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over a header store with coalescing on free.
// ----------------------------------------------------------------------------
// Timing: an allocate walks the blocks one header at a time; a null or malformed
//   pointer answers without a header read, a stale or double free after one;
//   every answer waits while the output register still holds a word.
// Throughput: one word at a time; the walk reads one header per cycle from the
//   single read port of the header RAM.
// Reset and every zone_bytes write sweep the header RAM, one entry per cycle,
//   and accept no word meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_block_allocator import nfba_pkg::*; #(
	parameter int ZONE_MAX_BYTES     = 65536,
	parameter int BLOCK_HEADER_BYTES = 24,
	parameter int MIN_FRAGMENT_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ZONE_W-1:0] cfg_wdata,
	nfba_in_if.sink                in_ch,
	nfba_out_if.source             out_ch
);

	localparam int GRANS  = ZONE_MAX_BYTES / 8;
	localparam int IW     = $clog2(GRANS);
	localparam int GW     = IW + 1;
	localparam int SW     = (GW > NEED_W) ? GW : NEED_W;
	localparam int HW     = 2 * GW + 2;
	localparam int AW     = GW + 3;
	localparam int MIN_GR = MIN_FRAGMENT_BYTES / 8;
	localparam int ZRES   = ((32'(ZONE_RESET) > ZONE_MAX_BYTES) ?
		ZONE_MAX_BYTES : 32'(ZONE_RESET)) / 8;
	localparam logic [GW-1:0] CAP_ID = {1'b1, {IW{1'b0}}};

	// Next block in address order; the end cap follows the last block
	function automatic logic [GW-1:0] nxt(input logic [GW-1:0] b,
			input logic [GW-1:0] sz, input logic [GW-1:0] ze);
		logic [GW:0] s;
		s = {1'b0, b} + {1'b0, sz};
		if (b[GW-1]) nxt = (ze != '0) ? '0 : CAP_ID;
		else if (s >= {1'b0, ze}) nxt = CAP_ID;
		else nxt = s[GW-1:0];
	endfunction

	function automatic logic [HW-1:0] pk(input logic mark, input logic used,
			input logic [GW-1:0] prev, input logic [GW-1:0] size);
		pk = {mark, used, prev, size};
	endfunction

	fsm_t state_q;

	logic [GW-1:0] zend_q, rover_q, tail_q;
	logic [IW-1:0] cnt_q;
	logic [GW-1:0] hid_q;
	logic [NEED_W-1:0] need_q;

	// Walk registers
	logic [GW-1:0] r_q, fb_q, start_q, fbs_q, fbp_q;
	logic          fbu_q, fbeq_q, pend_q;

	// Free registers
	logic [GW-1:0] b_q, bs_q, bp_q, ps_q, pp_q, p_q, n0_q, ns_q, np_q, nn_q;
	logic          pu_q, nu_q, nm_q;

	// Write slots
	logic [IW-1:0] wa_q [4];
	logic [HW-1:0] wd_q [4];
	logic          we_q [4];
	logic [1:0]    wk_q;

	// Staged and shown result
	logic [2:0]       rs_st_q, st_q;
	logic [OFF_W-1:0] rs_ro_q, ro_q;
	logic [BB_W-1:0]  rs_bb_q, bb_q;
	logic             ov_q;

	// RAM ports
	logic          ram_we;
	logic [IW-1:0] ram_wa;
	logic [HW-1:0] ram_wd, ram_rd;
	logic [GW-1:0] rid_c;

	nfba_ram #(.WIDTH(HW), .DEPTH(GRANS)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (rid_c[IW-1:0]),
		.rdata (ram_rd)
	);

	// Decode the header just read; the end cap is synthesized
	logic          cur_mark, cur_used;
	logic [GW-1:0] cur_prev, cur_size;
	always_comb begin
		if (hid_q[GW-1]) begin
			cur_mark = 1'b0;
			cur_used = 1'b1;
			cur_prev = tail_q;
			cur_size = '0;
		end else begin
			cur_mark = ram_rd[HW-1];
			cur_used = ram_rd[HW-2];
			cur_prev = ram_rd[2*GW-1:GW];
			cur_size = ram_rd[GW-1:0];
		end
	end

	// Walk step
	logic          fbu_c, found_c, split_c;
	logic [GW-1:0] fbs_c, fbp_c, nr_c, left_c, nsz_c, after_c, nb_c, nrov_c;
	always_comb begin
		fbu_c   = fbeq_q ? cur_used : fbu_q;
		fbs_c   = fbeq_q ? cur_size : fbs_q;
		fbp_c   = fbeq_q ? cur_prev : fbp_q;
		found_c = pend_q && !fbu_c && (SW'(fbs_c) >= SW'(need_q));
		nr_c    = nxt(r_q, cur_size, zend_q);
		left_c  = GW'(SW'(fbs_c) - SW'(need_q));
		split_c = SW'(left_c) > SW'(MIN_GR);
		nsz_c   = split_c ? GW'(need_q) : fbs_c;
		after_c = nxt(fb_q, fbs_c, zend_q);
		nb_c    = fb_q + GW'(need_q);
		nrov_c  = nxt(fb_q, nsz_c, zend_q);
	end

	// Pointer checks on a free request
	logic [OFF_W-1:0] addr_c;
	logic [GW-1:0]    bid_c;
	logic             badp_c;
	always_comb begin
		addr_c = in_ch.data_offset - OFF_W'(BLOCK_HEADER_BYTES);
		bid_c  = GW'(addr_c[OFF_W-1:3]);
		badp_c = (32'(in_ch.data_offset) < 32'(BLOCK_HEADER_BYTES)) ||
			(addr_c[2:0] != 3'd0) ||
			(32'(addr_c[OFF_W-1:3]) >= 32'(zend_q)) ||
			(32'(addr_c[OFF_W-1:3]) >= 32'(GRANS));
	end

	// Merge decisions
	logic          mp_c, mn_c;
	logic [GW-1:0] n0_c, nn_c, h_c, hp_c, hs_c, r1_c;
	always_comb begin
		n0_c = nxt(b_q, cur_size, zend_q);
		nn_c = nxt(n0_q, cur_size, zend_q);
		mp_c = !pu_q;
		mn_c = !nu_q;
		h_c  = mp_c ? p_q : b_q;
		hp_c = mp_c ? pp_q : bp_q;
		hs_c = (mp_c ? ps_q : '0) + bs_q + (mn_c ? ns_q : '0);
		r1_c = (mp_c && rover_q == b_q) ? p_q : rover_q;
	end

	// Read address, chosen so that the header is ready in the next state
	always_comb begin
		case (state_q)
			FS_IDLE:  rid_c = (in_ch.func == FUNC_FREE) ? bid_c : rover_q;
			FS_A_ST:  rid_c = r_q;
			FS_A_EV:  rid_c = found_c ? after_c : nr_c;
			FS_F_B:   rid_c = cur_prev[GW-1] ? n0_c : cur_prev;
			FS_F_P:   rid_c = n0_q;
			FS_F_N:   rid_c = nn_c;
			default:  rid_c = r_q;
		endcase
	end

	// Write port: sweep, initial block, or the queued slots
	always_comb begin
		ram_we = 1'b0;
		ram_wa = wa_q[wk_q];
		ram_wd = wd_q[wk_q];
		case (state_q)
			FS_CLR: begin
				ram_we = 1'b1;
				ram_wa = cnt_q;
				ram_wd = '0;
			end
			FS_INIT: begin
				ram_we = (zend_q != '0);
				ram_wa = '0;
				ram_wd = pk(1'b1, 1'b0, CAP_ID, zend_q);
			end
			FS_WR: ram_we = we_q[wk_q];
			default: ram_we = 1'b0;
		endcase
	end

	assign in_ch.ready          = (state_q == FS_IDLE);
	assign out_ch.valid         = ov_q;
	assign out_ch.status        = st_q;
	assign out_ch.result_offset = ro_q;
	assign out_ch.block_bytes   = bb_q;

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_CLR;
			cnt_q   <= '0;
			zend_q  <= GW'(ZRES);
			rover_q <= '0;
			tail_q  <= '0;
			wk_q    <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < 4; i++) we_q[i] <= 1'b0;
		end else begin
			hid_q <= rid_c;
			// Drop the shown word once taken, unless a new one replaces it
			if (ov_q && out_ch.ready && !(state_q == FS_FIN && !cfg_we)) ov_q <= 1'b0;
			if (cfg_we) begin
				// Take the new zone size and rebuild from scratch
				zend_q  <= (32'(cfg_wdata) > 32'(ZONE_MAX_BYTES)) ?
					CAP_ID : GW'(cfg_wdata[ZONE_W-1:3]);
				cnt_q   <= '0;
				state_q <= FS_CLR;
			end else begin
				case (state_q)
					FS_CLR: begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '1) state_q <= FS_INIT;
					end
					FS_INIT: begin
						rover_q <= (zend_q != '0) ? '0 : CAP_ID;
						tail_q  <= (zend_q != '0) ? '0 : CAP_ID;
						state_q <= FS_IDLE;
					end
					FS_IDLE: begin
						if (in_ch.valid) begin
							wk_q    <= '0;
							rs_ro_q <= '0;
							rs_bb_q <= '0;
							for (int i = 0; i < 4; i++) we_q[i] <= 1'b0;
							if (in_ch.func == FUNC_ALLOC) begin
								need_q  <= NEED_W'((17'(in_ch.req_bytes) +
									17'(BLOCK_HEADER_BYTES + 11)) >> 3);
								r_q     <= rover_q;
								fb_q    <= rover_q;
								fbeq_q  <= 1'b1;
								pend_q  <= 1'b0;
								state_q <= FS_A_ST;
							end else if (in_ch.null_pointer) begin
								rs_st_q <= STAT_NULL;
								state_q <= FS_FIN;
							end else if (badp_c) begin
								rs_st_q <= STAT_BADMARK;
								state_q <= FS_FIN;
							end else begin
								b_q     <= bid_c;
								state_q <= FS_F_B;
							end
						end
					end
					FS_A_ST: begin
						start_q <= cur_prev;
						state_q <= FS_A_EV;
					end
					FS_A_EV: begin
						if (found_c) begin
							// Take this block, split off a large remainder
							rs_st_q  <= STAT_OK;
							rs_ro_q  <= OFF_W'(AW'({fb_q, 3'b000}) + AW'(BLOCK_HEADER_BYTES));
							rs_bb_q  <= BB_W'({nsz_c, 3'b000});
							rover_q  <= nrov_c;
							we_q[0]  <= 1'b1;
							wa_q[0]  <= fb_q[IW-1:0];
							wd_q[0]  <= pk(1'b1, 1'b1, fbp_c, nsz_c);
							we_q[1]  <= split_c;
							wa_q[1]  <= nb_c[IW-1:0];
							wd_q[1]  <= pk(1'b1, 1'b0, fb_q, left_c);
							if (split_c && after_c[GW-1]) tail_q <= nb_c;
							fbp_q    <= nb_c;
							state_q  <= (split_c && !after_c[GW-1]) ? FS_A_AFT : FS_WR;
						end else if (r_q == start_q) begin
							rs_st_q <= STAT_NOSPACE;
							state_q <= FS_FIN;
						end else begin
							// Advance the walk one block
							if (cur_used) begin
								fb_q   <= nr_c;
								fbeq_q <= 1'b1;
							end else if (fbeq_q) begin
								fbu_q  <= cur_used;
								fbs_q  <= cur_size;
								fbp_q  <= cur_prev;
								fbeq_q <= 1'b0;
							end
							r_q    <= nr_c;
							pend_q <= 1'b1;
						end
					end
					FS_A_AFT: begin
						we_q[2] <= 1'b1;
						wa_q[2] <= hid_q[IW-1:0];
						wd_q[2] <= pk(cur_mark, cur_used, fbp_q, cur_size);
						state_q <= FS_WR;
					end
					FS_F_B: begin
						if (!cur_mark) begin
							rs_st_q <= STAT_BADMARK;
							state_q <= FS_FIN;
						end else if (!cur_used) begin
							rs_st_q <= STAT_DOUBLE;
							state_q <= FS_FIN;
						end else begin
							bs_q    <= cur_size;
							bp_q    <= cur_prev;
							p_q     <= cur_prev;
							n0_q    <= n0_c;
							pu_q    <= 1'b1;
							state_q <= cur_prev[GW-1] ? FS_F_N : FS_F_P;
						end
					end
					FS_F_P: begin
						pu_q    <= cur_used;
						ps_q    <= cur_size;
						pp_q    <= cur_prev;
						state_q <= FS_F_N;
					end
					FS_F_N: begin
						nu_q    <= cur_used;
						nm_q    <= cur_mark;
						ns_q    <= cur_size;
						np_q    <= cur_prev;
						nn_q    <= nn_c;
						state_q <= FS_F_CAL;
					end
					FS_F_CAL: begin
						// Queue the merged header, stale headers and back links
						rs_st_q <= STAT_OK;
						rs_bb_q <= BB_W'({hs_c, 3'b000});
						we_q[0] <= 1'b1;
						wa_q[0] <= h_c[IW-1:0];
						wd_q[0] <= pk(1'b1, 1'b0, hp_c, hs_c);
						we_q[1] <= mp_c;
						wa_q[1] <= b_q[IW-1:0];
						wd_q[1] <= pk(1'b0, 1'b0, bp_q, bs_q);
						wa_q[2] <= n0_q[IW-1:0];
						if (mn_c) begin
							we_q[2] <= 1'b1;
							wd_q[2] <= pk(1'b0, 1'b0, np_q, ns_q);
						end else begin
							we_q[2] <= mp_c && !n0_q[GW-1];
							wd_q[2] <= pk(nm_q, nu_q, h_c, ns_q);
						end
						we_q[3] <= mn_c && !nn_q[GW-1];
						wa_q[3] <= nn_q[IW-1:0];
						wd_q[3] <= pk(cur_mark, cur_used, h_c, cur_size);
						if ((mn_c && nn_q[GW-1]) || (!mn_c && mp_c && n0_q[GW-1]))
							tail_q <= h_c;
						rover_q <= (mn_c && r1_c == n0_q) ? h_c : r1_c;
						state_q <= FS_WR;
					end
					FS_WR: begin
						wk_q <= wk_q + 1'b1;
						if (wk_q == 2'd3) state_q <= FS_FIN;
					end
					FS_FIN: begin
						// Hand the result to the output register once it is free
						if (!ov_q || out_ch.ready) begin
							ov_q    <= 1'b1;
							st_q    <= rs_st_q;
							ro_q    <= rs_ro_q;
							bb_q    <= rs_bb_q;
							state_q <= FS_IDLE;
						end
					end
					default: state_q <= FS_IDLE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_CLR || state_q == FS_INIT) |-> !in_ch.ready)
		else $error("word accepted during header sweep");
	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_IDLE) |-> (rover_q <= CAP_ID && tail_q <= CAP_ID))
		else $error("rover or tail beyond end cap");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !cfg_we) |=> (state_q != FS_IDLE))
		else $error("accepted word did not start work");
`endif

endmodule

`default_nettype wire

FILE: src/nfba_ram.sv
// ----------------------------------------------------------------------------
// nfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
